// File: rtl/bq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad filter package
// Widths, microcode word layout, the control program and the saturation
// helpers shared by the biquad sequencer and its datapath.
// ---------------------------------------------------------------------------
package bq_pkg;

   localparam int CoefW   = 32;  // Q4.28 coefficient
   localparam int SampleW = 24;  // Q1.23 sample
   localparam int WideW   = 40;  // internal output and delay words
   localparam int AccW    = 46;  // exact sums before saturation
   localparam int HalfW   = 20;  // operand half fed to the multiplier
   localparam int OpndW   = HalfW + 1;
   localparam int ProdW   = CoefW + OpndW;
   localparam int FracW   = 28;
   localparam int PartW   = ProdW - HalfW;
   localparam int TermW   = ProdW - (FracW - HalfW);
   localparam int NumCoef = 5;
   localparam int IdxW    = 3;
   localparam int StepW   = 4;

   localparam logic signed [CoefW-1:0] CoefOne = 32'sh1000_0000;
   // Half an LSB of the rounded product, added before the shift by FracW.
   localparam logic signed [ProdW-1:0] RoundBias = 53'sd134217728;

   localparam logic signed [WideW-1:0] WideMax = {1'b0, {(WideW-1){1'b1}}};
   localparam logic signed [WideW-1:0] WideMin = {1'b1, {(WideW-1){1'b0}}};
   localparam logic signed [SampleW-1:0] OutMax = {1'b0, {(SampleW-1){1'b1}}};
   localparam logic signed [SampleW-1:0] OutMin = {1'b1, {(SampleW-1){1'b0}}};

   // Coefficient select, equal to the register index of each coefficient.
   typedef enum logic [IdxW-1:0] {
      COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2
   } coef_sel_type;

   typedef enum logic { OPND_X, OPND_Y } opnd_type;
   typedef enum logic { HALF_LO, HALF_HI } half_type;

   // Action taken on the product registered by the previous step.
   typedef enum logic [2:0] {
      POST_NONE, POST_LO, POST_Y, POST_D1_LOAD,
      POST_D2_LOAD, POST_D1_SUB, POST_D2_SUB, POST_COMMIT
   } post_type;

   typedef enum logic { SEQ_NEXT, SEQ_FINISH } seq_type;

   typedef struct packed {
      coef_sel_type coef;
      opnd_type     opnd;
      half_type     half;
      post_type     post;
      seq_type      seq;
   } uword_type;

   typedef struct packed {
      logic      load;
      logic      step;
      uword_type uw;
   } dp_ctrl_type;

   // Control program. Each product takes two multiplier passes (low half,
   // then high half of the operand); the post field of a word acts on the pass
   // of the previous word, keeping its low part or finishing the product.
   function automatic uword_type ucode(input logic [StepW-1:0] pc);
      uword_type w;
      unique case (pc)
         4'd0:    w = '{COEF_B0, OPND_X, HALF_LO, POST_NONE,    SEQ_NEXT};
         4'd1:    w = '{COEF_B0, OPND_X, HALF_HI, POST_LO,      SEQ_NEXT};
         4'd2:    w = '{COEF_B1, OPND_X, HALF_LO, POST_Y,       SEQ_NEXT};
         4'd3:    w = '{COEF_B1, OPND_X, HALF_HI, POST_LO,      SEQ_NEXT};
         4'd4:    w = '{COEF_B2, OPND_X, HALF_LO, POST_D1_LOAD, SEQ_NEXT};
         4'd5:    w = '{COEF_B2, OPND_X, HALF_HI, POST_LO,      SEQ_NEXT};
         4'd6:    w = '{COEF_A1, OPND_Y, HALF_LO, POST_D2_LOAD, SEQ_NEXT};
         4'd7:    w = '{COEF_A1, OPND_Y, HALF_HI, POST_LO,      SEQ_NEXT};
         4'd8:    w = '{COEF_A2, OPND_Y, HALF_LO, POST_D1_SUB,  SEQ_NEXT};
         4'd9:    w = '{COEF_A2, OPND_Y, HALF_HI, POST_LO,      SEQ_NEXT};
         4'd10:   w = '{COEF_B0, OPND_X, HALF_LO, POST_D2_SUB,  SEQ_NEXT};
         4'd11:   w = '{COEF_B0, OPND_X, HALF_LO, POST_COMMIT,  SEQ_FINISH};
         default: w = '{COEF_B0, OPND_X, HALF_LO, POST_NONE,    SEQ_NEXT};
      endcase
      return w;
   endfunction

   function automatic logic signed [WideW-1:0] sat_wide(input logic signed [AccW-1:0] v);
      logic signed [WideW-1:0] r;
      if (v > AccW'(WideMax)) begin
         r = WideMax;
      end else if (v < AccW'(WideMin)) begin
         r = WideMin;
      end else begin
         r = v[WideW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SampleW-1:0] sat_out(input logic signed [WideW-1:0] v);
      logic signed [SampleW-1:0] r;
      if (v > WideW'(OutMax)) begin
         r = OutMax;
      end else if (v < WideW'(OutMin)) begin
         r = OutMin;
      end else begin
         r = v[SampleW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad datapath
// Shared 32x21 multiplier, rounding, accumulators and the two delay words,
// stepped one control word per cycle by the sequencer, save while the final step waits.
// ---------------------------------------------------------------------------
module bq_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bq_pkg::dp_ctrl_type                 ctrl,
   input  wire logic signed [bq_pkg::SampleW-1:0]   sample_x,
   input  wire logic signed [bq_pkg::CoefW-1:0]     coef,
   output logic signed [bq_pkg::SampleW-1:0]        y_sat,
   output logic                                     y_clip
);

   logic signed [bq_pkg::SampleW-1:0] x_ff;
   logic signed [bq_pkg::WideW-1:0]   y_ff, y_in;
   logic signed [bq_pkg::WideW-1:0]   d1_ff, d1_in, d2_ff, d2_in;
   logic signed [bq_pkg::AccW-1:0]    acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [bq_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic signed [bq_pkg::PartW-1:0]   part_ff, part_in;

   logic signed [bq_pkg::WideW-1:0]   opnd_v;
   logic signed [bq_pkg::OpndW-1:0]   mul_b;
   logic signed [bq_pkg::ProdW-1:0]   lo_sum, mid;
   logic signed [bq_pkg::TermW-1:0]   term;
   logic signed [bq_pkg::AccW-1:0]    term_ext;

   assign opnd_v = (ctrl.uw.opnd == bq_pkg::OPND_X) ? bq_pkg::WideW'(x_ff) : y_ff;

   // The low half enters unsigned, the high half carries the sign.
   assign mul_b = (ctrl.uw.half == bq_pkg::HALF_HI)
                ? bq_pkg::OpndW'($signed(opnd_v[bq_pkg::WideW-1:bq_pkg::HalfW]))
                : $signed({1'b0, opnd_v[bq_pkg::HalfW-1:0]});

   assign prod_in = coef * mul_b;

   // Low partial product plus rounding bias, reduced by the low-half weight.
   assign lo_sum  = prod_ff + bq_pkg::RoundBias;
   assign part_in = lo_sum[bq_pkg::ProdW-1:bq_pkg::HalfW];

   // High partial product plus the carried low part gives the rounded term.
   assign mid      = prod_ff + bq_pkg::ProdW'(part_ff);
   assign term     = mid[bq_pkg::ProdW-1:bq_pkg::FracW-bq_pkg::HalfW];
   assign term_ext = bq_pkg::AccW'(term);

   always_comb begin
      y_in    = y_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      d1_in   = d1_ff;
      d2_in   = d2_ff;
      unique case (ctrl.uw.post)
         bq_pkg::POST_NONE, bq_pkg::POST_LO: begin
         end
         bq_pkg::POST_Y: begin
            y_in = bq_pkg::sat_wide(bq_pkg::AccW'(d1_ff) + term_ext);
         end
         bq_pkg::POST_D1_LOAD: begin
            acc1_in = bq_pkg::AccW'(d2_ff) + term_ext;
         end
         bq_pkg::POST_D2_LOAD: begin
            acc2_in = term_ext;
         end
         bq_pkg::POST_D1_SUB: begin
            acc1_in = acc1_ff - term_ext;
         end
         bq_pkg::POST_D2_SUB: begin
            acc2_in = acc2_ff - term_ext;
         end
         bq_pkg::POST_COMMIT: begin
            d1_in = bq_pkg::sat_wide(acc1_ff);
            d2_in = bq_pkg::sat_wide(acc2_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         x_ff <= sample_x;
      end
      if (ctrl.step) begin
         prod_ff <= prod_in;
         if (ctrl.uw.post == bq_pkg::POST_LO) begin
            part_ff <= part_in;
         end
         y_ff    <= y_in;
         acc1_ff <= acc1_in;
         acc2_ff <= acc2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctrl.step) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign y_sat  = bq_pkg::sat_out(y_ff);
   assign y_clip = ~((&y_ff[bq_pkg::WideW-1:bq_pkg::SampleW-1]) |
                     ~(|y_ff[bq_pkg::WideW-1:bq_pkg::SampleW-1]));

endmodule
`default_nettype wire

// File: rtl/biquad_df2t_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad filter, transposed direct form II
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_sample_in (s24 Q1.23)
// rsp       out        rsp_valid/rsp_stall   rsp_sample_out (s24), rsp_clipped
// csr       in         csr_write             csr_index (3), csr_wdata (32)
//
// A sample is accepted and then run through twelve microcode steps, which make
// ten passes through the single 32x21 multiplier, each 40-bit operand being
// multiplied in two halves.
// Reset loads unity gain (b0 = 1.0, others 0) and clears both delay words.
// A result waits in the output register while a new sample is accepted; the
// final step holds until the previous result has been taken.
// ---------------------------------------------------------------------------
module biquad_df2t_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [bq_pkg::SampleW-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [bq_pkg::SampleW-1:0]      rsp_sample_out,
   output logic                                   rsp_clipped,
   input  wire logic                              csr_write,
   input  wire logic [bq_pkg::IdxW-1:0]           csr_index,
   input  wire logic [bq_pkg::CoefW-1:0]          csr_wdata
);

   logic signed [bq_pkg::CoefW-1:0] coef_ff [bq_pkg::NumCoef];

   logic                            busy_ff;
   logic [bq_pkg::StepW-1:0]        pc_ff;
   logic                            rsp_valid_ff;
   logic signed [bq_pkg::SampleW-1:0] rsp_sample_ff;
   logic                            rsp_clipped_ff;

   bq_pkg::uword_type               uw;
   bq_pkg::dp_ctrl_type             dp_ctrl;
   logic                            accept;
   logic                            out_free;
   logic                            step;
   logic                            finish;
   logic signed [bq_pkg::SampleW-1:0] y_sat;
   logic                            y_clip;

   assign uw       = bq_pkg::ucode(pc_ff);
   assign accept   = req_valid && !busy_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // The finishing step is the only conditional one: it waits for room.
   assign step     = busy_ff && ((uw.seq == bq_pkg::SEQ_NEXT) || out_free);
   assign finish   = step && (uw.seq == bq_pkg::SEQ_FINISH);

   assign dp_ctrl.load = accept;
   assign dp_ctrl.step = step;
   assign dp_ctrl.uw   = uw;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[bq_pkg::COEF_B0] <= bq_pkg::CoefOne;
         coef_ff[bq_pkg::COEF_B1] <= '0;
         coef_ff[bq_pkg::COEF_B2] <= '0;
         coef_ff[bq_pkg::COEF_A1] <= '0;
         coef_ff[bq_pkg::COEF_A2] <= '0;
      end else if (csr_write && (csr_index < bq_pkg::IdxW'(bq_pkg::NumCoef))) begin
         coef_ff[csr_index] <= $signed(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            pc_ff   <= '0;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end else if (step) begin
            pc_ff <= pc_ff + 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_sample_ff  <= y_sat;
         rsp_clipped_ff <= y_clip;
      end
   end

   bq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dp_ctrl),
      .sample_x (req_sample_in),
      .coef     (coef_ff[uw.coef]),
      .y_sat    (y_sat),
      .y_clip   (y_clip)
   );

   assign req_stall      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule
`default_nettype wire

// File: rtl/bq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Biquad port checker
// Watches the top-level ports for handshake, sequencing and clipping errors.
// ---------------------------------------------------------------------------
module bq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [bq_pkg::SampleW-1:0] rsp_sample_out,
   input wire logic                              rsp_clipped
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("stalled result changed");

   // One sample is processed at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second sample accepted while busy");

   // A new result only appears at the end of a processing run.
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a sample in flight");

   // A clipped result sits at one of the full-scale limits.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> (rsp_sample_out == bq_pkg::OutMax) ||
                                   (rsp_sample_out == bq_pkg::OutMin))
      else $error("clip flag without full-scale output");

   // Reset leaves both channels idle.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");

endmodule

bind biquad_df2t_filter bq_checker u_bq_checker (.*);
`default_nettype wire

// File: test/biquad_df2t_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Biquad filter testbench
// Drives samples through the filter under several coefficient sets and
// handshake pressures, predicts each output sample with a bit-exact model of
// the fixed-point recurrence, and compares every accepted result in order.
// ---------------------------------------------------------------------------
module biquad_df2t_filter_tb;

   localparam int DrainCycles = 20;
   localparam int RandomItems = 1700;

   localparam logic signed [bq_pkg::SampleW-1:0] SampleHi = 24'sh7F_FFFF;
   localparam logic signed [bq_pkg::SampleW-1:0] SampleLo = 24'sh80_0000;
   localparam logic signed [bq_pkg::CoefW-1:0]   CoefHi   = 32'sh7FFF_FFFF;
   localparam logic signed [bq_pkg::CoefW-1:0]   CoefLo   = 32'sh8000_0000;
   localparam logic signed [bq_pkg::CoefW-1:0]   CoefHalf = 32'sh0800_0000;

   // Register indexes past the last coefficient; writes to them are dropped.
   localparam logic [bq_pkg::IdxW-1:0] IdxSpareFirst = 3'd5;
   localparam logic [bq_pkg::IdxW-1:0] IdxSpareLast  = 3'd7;

   localparam logic signed [95:0] HalfLsb = 96'sd134217728;
   localparam logic signed [95:0] WideHi  = 96'sd549755813887;
   localparam logic signed [95:0] WideLo  = -96'sd549755813888;
   localparam logic signed [bq_pkg::WideW-1:0] OutHi = 40'sd8388607;
   localparam logic signed [bq_pkg::WideW-1:0] OutLo = -40'sd8388608;

   // Largest |a2| of a stable set, 0.9 in Q4.28.
   localparam int StableA2 = 241591910;

   typedef struct packed {
      logic signed [bq_pkg::SampleW-1:0] sample_out;
      logic                              clipped;
   } filt_result_type;

   typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [bq_pkg::IdxW-1:0]           idx;
      logic [bq_pkg::CoefW-1:0]          wdata;
      logic signed [bq_pkg::SampleW-1:0] x;
      logic                              typed;
      filt_result_type                   given;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [bq_pkg::SampleW-1:0] req_sample_in = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [bq_pkg::SampleW-1:0] rsp_sample_out;
   logic                              rsp_clipped;
   logic                              csr_write = 1'b0;
   logic [bq_pkg::IdxW-1:0]           csr_index = '0;
   logic [bq_pkg::CoefW-1:0]          csr_wdata = '0;

   // Filter state as the predictor sees it.
   logic signed [bq_pkg::CoefW-1:0] coef_reg [bq_pkg::NumCoef];
   logic signed [bq_pkg::WideW-1:0] delay_first;
   logic signed [bq_pkg::WideW-1:0] delay_second;

   filt_result_type expected_q [$];
   int              mismatch_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;

   stim_row_type directed_rows [36];

   biquad_df2t_filter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // round(c * v / 2^28), ties toward plus infinity, formed exactly.
   function automatic logic signed [95:0] round_product(
         input logic signed [bq_pkg::CoefW-1:0] c,
         input logic signed [bq_pkg::WideW-1:0] v);
      logic signed [95:0] cw;
      logic signed [95:0] vw;
      cw = c;
      vw = v;
      return (cw * vw + HalfLsb) >>> 28;
   endfunction

   function automatic logic signed [bq_pkg::WideW-1:0] clamp_wide(input logic signed [95:0] v);
      if (v > WideHi) begin
         return WideHi[bq_pkg::WideW-1:0];
      end else if (v < WideLo) begin
         return WideLo[bq_pkg::WideW-1:0];
      end
      return v[bq_pkg::WideW-1:0];
   endfunction

   function automatic filt_result_type filter_step(
         input logic signed [bq_pkg::SampleW-1:0] x);
      logic signed [95:0]              acc_y;
      logic signed [95:0]              acc_d1;
      logic signed [95:0]              acc_d2;
      logic signed [bq_pkg::WideW-1:0] y;
      filt_result_type                 res;
      acc_y  = round_product(coef_reg[bq_pkg::COEF_B0], x) + delay_first;
      y      = clamp_wide(acc_y);
      acc_d1 = round_product(coef_reg[bq_pkg::COEF_B1], x)
               - round_product(coef_reg[bq_pkg::COEF_A1], y) + delay_second;
      acc_d2 = round_product(coef_reg[bq_pkg::COEF_B2], x)
               - round_product(coef_reg[bq_pkg::COEF_A2], y);
      delay_first  = clamp_wide(acc_d1);
      delay_second = clamp_wide(acc_d2);
      if (y > OutHi) begin
         res = '{SampleHi, 1'b1};
      end else if (y < OutLo) begin
         res = '{SampleLo, 1'b1};
      end else begin
         res = '{y[bq_pkg::SampleW-1:0], 1'b0};
      end
      return res;
   endfunction

   function automatic stim_row_type reg_row(input logic [bq_pkg::IdxW-1:0] idx,
                                            input logic [bq_pkg::CoefW-1:0] val);
      stim_row_type r;
      r = '0;
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.wdata = val;
      return r;
   endfunction

   function automatic stim_row_type sample_row(input logic signed [bq_pkg::SampleW-1:0] x);
      stim_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.x    = x;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic signed [bq_pkg::SampleW-1:0] x,
                                              input logic signed [bq_pkg::SampleW-1:0] out,
                                              input logic clip);
      stim_row_type r;
      r = sample_row(x);
      r.typed = 1'b1;
      r.given = '{out, clip};
      return r;
   endfunction

   function automatic logic signed [bq_pkg::SampleW-1:0] rand_sample();
      case ($urandom_range(9))
         0: return SampleHi;
         1: return SampleLo;
         2: return '0;
         3, 4: return bq_pkg::SampleW'(int'($urandom_range(2047)) - 1024);
         default: return bq_pkg::SampleW'($urandom);
      endcase
   endfunction

   function automatic logic signed [bq_pkg::CoefW-1:0] extreme_coef();
      case ($urandom_range(4))
         0: return CoefHi;
         1: return CoefLo;
         2: return '0;
         3: return bq_pkg::CoefOne;
         default: return -bq_pkg::CoefOne;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic write_reg(input logic [bq_pkg::IdxW-1:0] idx,
                            input logic [bq_pkg::CoefW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx < bq_pkg::NumCoef) begin
         coef_reg[idx] = val;
      end
   endtask

   // Waits for the last result, then gives the block time to go idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [bq_pkg::SampleW-1:0] x,
                              input logic use_given,
                              input filt_result_type given);
      filt_result_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
      // The predictor runs on every sample so that its state tracks the block.
      predicted = filter_step(x);
      expected_q.push_back(use_given ? given : predicted);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      filt_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result sample_out=%0d clipped=%0b",
                                      rsp_sample_out, rsp_clipped));
         end else begin
            want = expected_q.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               report_mismatch($sformatf("sample_out got %0d, want %0d",
                                         rsp_sample_out, want.sample_out));
            end
            if (rsp_clipped !== want.clipped) begin
               report_mismatch($sformatf("clipped got %0b, want %0b",
                                         rsp_clipped, want.clipped));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("biquad_df2t_filter: mismatch");
      $finish;
   end

   initial begin
      logic signed [bq_pkg::CoefW-1:0] coef_set [bq_pkg::NumCoef];
      int random_sent;
      int phase;
      int a2;
      int lim;
      int style;

      coef_reg[bq_pkg::COEF_B0] = bq_pkg::CoefOne;
      coef_reg[bq_pkg::COEF_B1] = '0;
      coef_reg[bq_pkg::COEF_B2] = '0;
      coef_reg[bq_pkg::COEF_A1] = '0;
      coef_reg[bq_pkg::COEF_A2] = '0;
      delay_first  = '0;
      delay_second = '0;
      random_sent  = 0;
      phase        = 0;

      directed_rows = '{
         // Unity gain straight out of reset.
         known_row('0, '0, 1'b0),
         known_row(SampleHi, SampleHi, 1'b0),
         known_row(SampleLo, SampleLo, 1'b0),
         known_row(24'sd1, 24'sd1, 1'b0),
         known_row(-24'sd1, -24'sd1, 1'b0),
         // Gain near +8 and exactly -8 drive the output into saturation.
         reg_row(bq_pkg::COEF_B0, CoefHi),
         known_row(SampleHi, SampleHi, 1'b1),
         known_row(SampleLo, SampleLo, 1'b1),
         known_row('0, '0, 1'b0),
         reg_row(bq_pkg::COEF_B0, CoefLo),
         known_row(SampleHi, SampleLo, 1'b1),
         known_row(SampleLo, SampleHi, 1'b1),
         known_row(24'sd1, -24'sd8, 1'b0),
         // Gain of one half puts every odd sample on a rounding tie.
         reg_row(bq_pkg::COEF_B0, CoefHalf),
         known_row(24'sd1, 24'sd1, 1'b0),
         known_row(-24'sd1, '0, 1'b0),
         known_row(24'sd3, 24'sd2, 1'b0),
         known_row(-24'sd3, -24'sd1, 1'b0),
         // Extreme feedback makes the wide words overflow after an impulse.
         reg_row(bq_pkg::COEF_B1, CoefHi),
         reg_row(bq_pkg::COEF_B2, CoefLo),
         reg_row(bq_pkg::COEF_A1, CoefLo),
         reg_row(bq_pkg::COEF_A2, CoefHi),
         reg_row(bq_pkg::COEF_B0, bq_pkg::CoefOne),
         reg_row(IdxSpareFirst, 32'h5A5A_A5A5),
         reg_row(IdxSpareFirst + 3'd1, 32'hFFFF_FFFF),
         reg_row(IdxSpareLast, 32'h0000_0000),
         sample_row(SampleHi),
         sample_row('0),
         sample_row('0),
         sample_row('0),
         sample_row('0),
         sample_row('0),
         sample_row('0),
         sample_row(SampleLo),
         sample_row('0),
         sample_row('0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      stall_pct     = 6;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            send_sample(directed_rows[i].x, directed_rows[i].typed, directed_rows[i].given);
         end
      end

      while (random_sent < RandomItems) begin
         settle();
         style = $urandom_range(9);
         for (int r = 0; r < bq_pkg::NumCoef; r++) begin
            if (style >= 8) begin
               coef_set[r] = bq_pkg::CoefW'(int'($urandom_range(32'h4000_0000))
                                            - 32'sh2000_0000);
            end else if (style == 7) begin
               coef_set[r] = extreme_coef();
            end else if (style >= 5) begin
               coef_set[r] = $urandom;
            end else begin
               coef_set[r] = bq_pkg::CoefW'(int'($urandom_range(32'h2000_0000))
                                            - 32'sh1000_0000);
            end
         end
         // A stable pole pair keeps the state in range over long runs.
         if (style < 5) begin
            a2  = int'($urandom_range(2 * StableA2)) - StableA2;
            lim = ((32'sh1000_0000 + a2) / 10) * 9;
            coef_set[bq_pkg::COEF_A2] = a2;
            coef_set[bq_pkg::COEF_A1] = int'($urandom_range(2 * lim)) - lim;
         end
         for (int r = 0; r < bq_pkg::NumCoef; r++) begin
            write_reg(bq_pkg::IdxW'(r), coef_set[r]);
         end
         if ($urandom_range(2) == 0) begin
            write_reg(bq_pkg::IdxW'($urandom_range(IdxSpareLast, IdxSpareFirst)), $urandom);
         end

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 70;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 70;
            end
            default: begin
               send_idle_pct = 6;
               stall_pct     = 6;
            end
         endcase

         repeat ($urandom_range(140, 60)) begin
            send_sample(rand_sample(), 1'b0, '0);
            random_sent++;
         end
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("biquad_df2t_filter: match");
      end else begin
         $display("biquad_df2t_filter: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/bq_pkg.sv
rtl/bq_datapath.sv
rtl/biquad_df2t_filter.sv
rtl/bq_checker.sv
test/biquad_df2t_filter_tb.sv
